// File: hdl/clc_pkg.sv
// Package for the centered linear convolution block.
// Item types, job descriptor, status structs, state codes and saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package clc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int VALUE_W   = 37;
  localparam int POS_W     = 6;
  localparam int PROD_W    = 2 * SAMPLE_W;
  // Enough headroom for the sum of 64 full-scale products.
  localparam int ACC_W     = VALUE_W + 1;
  // Counts up to 64 travel through the job queue at this width.
  localparam int JOB_CNT_W = 7;

  localparam logic [1:0] REQ_SIGNAL = 2'd0;
  localparam logic [1:0] REQ_KERNEL = 2'd1;
  localparam logic [1:0] REQ_RUN    = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      last;
    logic                      empty_error;
  } out_item_t;

  typedef struct packed {
    logic                 err;
    logic [JOB_CNT_W-1:0] ls;
    logic [JOB_CNT_W-1:0] lk;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } back_state_t;

  // Clamp the wide accumulator into the signed output range.
  function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [ACC_W-1:0] acc);
    logic signed [VALUE_W-1:0] res;
    if (acc[ACC_W-1] != acc[ACC_W-2]) begin
      res = acc[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      res = acc[VALUE_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/clc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module clc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/clc_queue.sv
// Two-entry job queue between the front end and the MAC back end.
// Depends on clc_pkg.
`timescale 1ns / 1ps

module clc_queue
  import clc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head_job,
  output q_stat_t stat
);

  job_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign do_push = push && (cnt_r != 2'd2);
  assign do_pop  = pop && (cnt_r != 2'd0);

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  assign head_job   = slot_r[rptr_r];
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

endmodule

// File: hdl/clc_front.sv
// Front end: accepts items, writes signal and kernel samples, queues runs.
// Depends on clc_pkg.
`timescale 1ns / 1ps

module clc_front
  import clc_pkg::*;
#(
  parameter int MAX_LEN = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_data,
  input  q_stat_t                    q_stat,
  input  back_stat_t                 back_stat,
  output logic                       sig_we,
  output logic                       ker_we,
  output logic [$clog2(MAX_LEN)-1:0] waddr,
  output logic [SAMPLE_W-1:0]        wdata,
  output logic                       push,
  output job_t                       push_job
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);

  logic [CNT_W-1:0] sig_cnt_r, sig_cnt_nxt;
  logic [CNT_W-1:0] ker_cnt_r, ker_cnt_nxt;
  logic             accept;
  logic             load_ok;

  // Loads wait until every queued run has finished reading the stores.
  assign load_ok = q_stat.empty && !back_stat.busy;

  always_comb begin
    unique case (in_data.req_type)
      REQ_SIGNAL: in_ready = load_ok;
      REQ_KERNEL: in_ready = load_ok;
      REQ_RUN:    in_ready = !q_stat.full;
      REQ_NONE:   in_ready = 1'b1;
      default:    in_ready = 1'b1;
    endcase
  end

  assign accept = in_valid && in_ready;

  assign sig_we = accept && (in_data.req_type == REQ_SIGNAL) &&
                  (sig_cnt_r < CNT_W'(MAX_LEN));
  assign ker_we = accept && (in_data.req_type == REQ_KERNEL) &&
                  (ker_cnt_r < CNT_W'(MAX_LEN));
  assign waddr  = (in_data.req_type == REQ_SIGNAL) ? sig_cnt_r[IDX_W-1:0]
                                                   : ker_cnt_r[IDX_W-1:0];
  assign wdata  = in_data.sample;

  assign push         = accept && (in_data.req_type == REQ_RUN);
  assign push_job.err = (sig_cnt_r == '0) || (ker_cnt_r == '0);
  assign push_job.ls  = JOB_CNT_W'(sig_cnt_r);
  assign push_job.lk  = JOB_CNT_W'(ker_cnt_r);

  always_comb begin
    sig_cnt_nxt = sig_cnt_r;
    ker_cnt_nxt = ker_cnt_r;
    if (push) begin
      sig_cnt_nxt = '0;
      ker_cnt_nxt = '0;
    end else begin
      if (sig_we) begin
        sig_cnt_nxt = sig_cnt_r + 1'b1;
      end
      if (ker_we) begin
        ker_cnt_nxt = ker_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_cnt_r <= '0;
      ker_cnt_r <= '0;
    end else begin
      sig_cnt_r <= sig_cnt_nxt;
      ker_cnt_r <= ker_cnt_nxt;
    end
  end

endmodule

// File: hdl/clc_back.sv
// Back end: runs queued jobs through one multiply-accumulate pipeline and
// holds each result in an output register. Depends on clc_pkg.
`timescale 1ns / 1ps

module clc_back
  import clc_pkg::*;
#(
  parameter int MAX_LEN = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  q_stat_t                    q_stat,
  input  job_t                       head_job,
  output logic                       pop,
  output back_stat_t                 back_stat,
  output logic [$clog2(MAX_LEN)-1:0] sig_raddr,
  output logic [$clog2(MAX_LEN)-1:0] ker_raddr,
  input  logic [SAMPLE_W-1:0]        sig_rdata,
  input  logic [SAMPLE_W-1:0]        ker_rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_data
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int T_W   = CNT_W + 1;

  back_state_t state_r, state_nxt;
  logic [CNT_W-1:0] ls_r, ls_nxt;
  logic [CNT_W-1:0] lk_r, lk_nxt;
  logic [CNT_W-1:0] mlen_r, mlen_nxt;
  logic [CNT_W-1:0] half_r, half_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] m_r, m_nxt;
  logic             err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [CNT_W-1:0] job_ls, job_lk, job_klen;
  logic [T_W-1:0]   t_idx, k_idx;
  logic             tap_used, issue, end_now, last_out, out_free;

  // Pipeline: read issue, product, accumulate.
  logic                     v1_r, use1_r, first1_r, end1_r;
  logic                     v2_r, first2_r, end2_r;
  logic signed [PROD_W-1:0] prod1;
  logic signed [PROD_W-1:0] p2_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     done_r;

  assign job_ls   = CNT_W'(head_job.ls);
  assign job_lk   = CNT_W'(head_job.lk);
  assign job_klen = (job_ls > job_lk) ? job_lk : job_ls;

  // Output m needs kernel tap t - j with t = min(Ls, Lk)/2 + m, for every valid j.
  assign t_idx    = T_W'(half_r) + T_W'(m_r);
  assign k_idx    = t_idx - T_W'(j_r);
  assign tap_used = (T_W'(j_r) <= t_idx) && (k_idx < T_W'(lk_r));
  assign end_now  = (CNT_W'(j_r) + 1'b1) == ls_r;
  assign last_out = (CNT_W'(m_r) + 1'b1) == mlen_r;
  assign out_free = !out_valid_r || out_ready;

  assign sig_raddr = j_r;
  assign ker_raddr = k_idx[IDX_W-1:0];

  // The product is formed on its own so that both factors stay signed.
  assign prod1 = $signed(sig_rdata) * $signed(ker_rdata);

  always_comb begin
    state_nxt     = state_r;
    ls_nxt        = ls_r;
    lk_nxt        = lk_r;
    mlen_nxt      = mlen_r;
    half_nxt      = half_r;
    j_nxt         = j_r;
    m_nxt         = m_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    issue         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          ls_nxt   = job_ls;
          lk_nxt   = job_lk;
          mlen_nxt = (job_ls > job_lk) ? job_ls : job_lk;
          half_nxt = job_klen >> 1;
          j_nxt    = '0;
          m_nxt    = '0;
          err_nxt  = head_job.err;
          state_nxt = head_job.err ? ST_EMIT : ST_MAC;
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        if (end_now) begin
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (done_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_data_nxt.value       = '0;
            out_data_nxt.position    = '0;
            out_data_nxt.last        = 1'b1;
            out_data_nxt.empty_error = 1'b1;
            state_nxt                = ST_IDLE;
          end else begin
            out_data_nxt.value       = sat_value(acc_r);
            out_data_nxt.position    = POS_W'(m_r);
            out_data_nxt.last        = last_out;
            out_data_nxt.empty_error = 1'b0;
            if (last_out) begin
              state_nxt = ST_IDLE;
            end else begin
              m_nxt     = m_r + 1'b1;
              j_nxt     = '0;
              state_nxt = ST_MAC;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      done_r      <= v2_r && end2_r;
    end
  end

  always_ff @(posedge clk) begin
    ls_r       <= ls_nxt;
    lk_r       <= lk_nxt;
    mlen_r     <= mlen_nxt;
    half_r     <= half_nxt;
    j_r        <= j_nxt;
    m_r        <= m_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
    use1_r     <= tap_used;
    first1_r   <= (j_r == '0);
    end1_r     <= end_now;
    p2_r       <= use1_r ? prod1 : '0;
    first2_r   <= first1_r;
    end2_r     <= end1_r;
    if (v2_r) begin
      acc_r <= (first2_r ? '0 : acc_r) + ACC_W'(p2_r);
    end
  end

  assign back_stat.busy = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule

// File: hdl/centered_linear_convolution.sv
// Centered linear convolution: a load item is written to its sample store
// when accepted; a run item with signal length Ls and longer length M
// yields M outputs of Ls steps each, on the single multiply-accumulate unit
// fed by one read port per sample store. Up to two runs can wait in the job
// queue. Reset clears both counts, the job queue, the sequencer and the
// output valid; the sample stores are not cleared.
`timescale 1ns / 1ps

module centered_linear_convolution
  import clc_pkg::*;
#(
  parameter int MAX_LEN = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = $clog2(MAX_LEN);

  logic                sig_we, ker_we;
  logic [IDX_W-1:0]    waddr;
  logic [SAMPLE_W-1:0] wdata;
  logic                push, pop;
  job_t                push_job, head_job;
  q_stat_t             q_stat;
  back_stat_t          back_stat;
  logic [IDX_W-1:0]    sig_raddr, ker_raddr;
  logic [SAMPLE_W-1:0] sig_rdata, ker_rdata;

  clc_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .back_stat (back_stat),
    .sig_we    (sig_we),
    .ker_we    (ker_we),
    .waddr     (waddr),
    .wdata     (wdata),
    .push      (push),
    .push_job  (push_job)
  );

  clc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (sig_raddr),
    .rdata (sig_rdata)
  );

  clc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_ker_ram (
    .clk   (clk),
    .we    (ker_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ker_raddr),
    .rdata (ker_rdata)
  );

  clc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  clc_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_job  (head_job),
    .pop       (pop),
    .back_stat (back_stat),
    .sig_raddr (sig_raddr),
    .ker_raddr (ker_raddr),
    .sig_rdata (sig_rdata),
    .ker_rdata (ker_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The stores must never change under a run that is reading them.
  assert property (@(posedge clk) disable iff (!rst_n)
    (sig_we || ker_we) |-> (!back_stat.busy && q_stat.empty))
    else $error("sample store written while a run is pending");

  // An accepted run item is held in the queue on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.req_type == REQ_RUN) |=> !q_stat.empty)
    else $error("accepted run item missing from job queue");

  // An empty-store result is always a single zero item closing its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.empty_error) |->
      (out_data.last && out_data.value == '0 && out_data.position == '0))
    else $error("malformed empty-store result");

endmodule
